// ===== rtl/pab_pkg.sv =====
// Package for the pixel alpha blend core: widths, register indexes,
// stage structs and the reciprocal constant for the divide by 65025.
// No dependencies.
package pab_pkg;

	localparam int PIX_W    = 32;
	localparam int CH_W     = 8;
	localparam int NUM_CH   = 3;
	localparam int WEIGHT_W = 16;
	localparam int NUM_W    = 24;

	localparam logic [WEIGHT_W-1:0] FULL_WEIGHT = 16'd65025;
	localparam logic [CH_W-1:0]     ALPHA_MAX   = 8'd255;

	// floor(n / 65025) == (n * RECIP) >> RECIP_SHIFT, exact for n < 2^24
	localparam int                RECIP_W     = 25;
	localparam int                RECIP_SHIFT = 40;
	localparam logic [RECIP_W-1:0] RECIP      = 25'd16909061;

	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 8;

	localparam logic [CFG_IDX_W-1:0] CFG_GLOBAL_ALPHA    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_USE_SRC_ALPHA   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_SRC_PREMULT     = 2'd2;

	typedef struct packed {
		logic [CH_W-1:0] global_alpha;
		logic            use_src_alpha;
		logic            src_premult;
	} cfg_t;

	typedef struct packed {
		logic [PIX_W-1:0]    dst;
		logic [PIX_W-1:0]    src;
		logic [WEIGHT_W-1:0] weight;
		logic                copy;
		logic                premult;
	} s1_t;

	typedef struct packed {
		logic s2;
		logic s3;
		logic s4;
	} stage_en_t;

endpackage

// ===== rtl/pab_if.sv =====
// Valid/ready channel interfaces of the pixel alpha blend core.
// Depends on pab_pkg.
interface pab_in_if;
	logic                      valid;
	logic                      ready;
	logic [pab_pkg::PIX_W-1:0] dst_pixel;
	logic [pab_pkg::PIX_W-1:0] src_pixel;

	modport source (output valid, output dst_pixel, output src_pixel, input ready);
	modport sink   (input valid, input dst_pixel, input src_pixel, output ready);
endinterface

interface pab_out_if;
	logic                      valid;
	logic                      ready;
	logic [pab_pkg::PIX_W-1:0] out_pixel;

	modport source (output valid, output out_pixel, input ready);
	modport sink   (input valid, input out_pixel, output ready);
endinterface

// ===== rtl/pixel_alpha_blend_core.sv =====
// Pixel alpha blend core (source-over, ARGB8888), top level.
// Depends on pab_pkg, pab_if, pab_weight and pab_lane.
//
// One destination/source pixel pair is accepted every clock while the
// output is not stalled. Stage 1 forms the weight (8x8 multiply),
// stage 2 the per-channel products, stage 3 the divide by 65025 as a
// reciprocal multiply, stage 4 the saturating add and the output register.
// Sustained rate is one pixel per cycle; back-pressure on the output
// holds every stage without loss. The user must write the configuration
// registers (0 global alpha, 1 use source alpha, 2 source premultiplied)
// only while the pipeline is empty; the core itself does not enforce it.
module pixel_alpha_blend_core (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [pab_pkg::CFG_IDX_W-1:0]  cfg_idx,
	input  logic [pab_pkg::CFG_DATA_W-1:0] cfg_data,
	pab_in_if.sink                         pix_in,
	pab_out_if.source                      pix_out
);
	import pab_pkg::*;

	cfg_t      cfg_q;
	s1_t       s1;
	stage_en_t en;

	logic vld_s1, vld_s2, vld_s3, vld_s4;
	logic adv1, adv2, adv3, adv4;

	logic             bypass_s2, bypass_s3, bypass_s4;
	logic [PIX_W-1:0] bypass_pix_s2, bypass_pix_s3, bypass_pix_s4;
	logic [CH_W-1:0]  lane_res [NUM_CH];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.global_alpha  <= ALPHA_MAX;
			cfg_q.use_src_alpha <= 1'b1;
			cfg_q.src_premult   <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				CFG_GLOBAL_ALPHA:  cfg_q.global_alpha  <= cfg_data;
				CFG_USE_SRC_ALPHA: cfg_q.use_src_alpha <= cfg_data[0];
				CFG_SRC_PREMULT:   cfg_q.src_premult   <= cfg_data[0];
				default: ;
			endcase
		end
	end

	assign adv4 = !vld_s4 || pix_out.ready;
	assign adv3 = !vld_s3 || adv4;
	assign adv2 = !vld_s2 || adv3;
	assign adv1 = !vld_s1 || adv2;

	assign pix_in.ready = adv1;
	assign en.s2        = adv2 && vld_s1;
	assign en.s3        = adv3 && vld_s2;
	assign en.s4        = adv4 && vld_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
		end else begin
			if (adv1) vld_s1 <= pix_in.valid;
			if (adv2) vld_s2 <= vld_s1;
			if (adv3) vld_s3 <= vld_s2;
			if (adv4) vld_s4 <= vld_s3;
		end
	end

	pab_weight u_weight (
		.clk       (clk),
		.en        (adv1 && pix_in.valid),
		.cfg       (cfg_q),
		.dst_pixel (pix_in.dst_pixel),
		.src_pixel (pix_in.src_pixel),
		.s1        (s1)
	);

	for (genvar k = 0; k < NUM_CH; k++) begin : g_lane
		pab_lane u_lane (
			.clk        (clk),
			.en         (en),
			.src_s1     (s1.src[k*CH_W +: CH_W]),
			.dst_s1     (s1.dst[k*CH_W +: CH_W]),
			.weight_s1  (s1.weight),
			.premult_s1 (s1.premult),
			.res_s4     (lane_res[k])
		);
	end

	// opaque copy or zero weight: pixel passes unchanged
	always_ff @(posedge clk) begin
		if (en.s2) begin
			bypass_s2     <= s1.copy || (s1.weight == '0);
			bypass_pix_s2 <= s1.copy ? s1.src : s1.dst;
		end
		if (en.s3) begin
			bypass_s3     <= bypass_s2;
			bypass_pix_s3 <= bypass_pix_s2;
		end
		if (en.s4) begin
			bypass_s4     <= bypass_s3;
			bypass_pix_s4 <= bypass_pix_s3;
		end
	end

	assign pix_out.valid     = vld_s4;
	assign pix_out.out_pixel = bypass_s4 ? bypass_pix_s4 :
	                           {{(PIX_W-NUM_CH*CH_W){1'b0}}, lane_res[2], lane_res[1], lane_res[0]};

endmodule

// ===== rtl/pab_weight.sv =====
// Stage 1: effective weight (source alpha times global alpha) and mode flags.
// Depends on pab_pkg.
module pab_weight (
	input  logic                      clk,
	input  logic                      en,
	input  pab_pkg::cfg_t             cfg,
	input  logic [pab_pkg::PIX_W-1:0] dst_pixel,
	input  logic [pab_pkg::PIX_W-1:0] src_pixel,
	output pab_pkg::s1_t              s1
);
	import pab_pkg::*;

	logic [CH_W-1:0]     src_alpha;
	logic [WEIGHT_W-1:0] weight;

	assign src_alpha = cfg.use_src_alpha ? src_pixel[PIX_W-1 -: CH_W] : ALPHA_MAX;
	assign weight    = {{(WEIGHT_W-CH_W){1'b0}}, src_alpha} *
	                   {{(WEIGHT_W-CH_W){1'b0}}, cfg.global_alpha};

	always_ff @(posedge clk) begin
		if (en) begin
			s1.dst     <= dst_pixel;
			s1.src     <= src_pixel;
			s1.weight  <= weight;
			s1.copy    <= !cfg.use_src_alpha && (cfg.global_alpha == ALPHA_MAX);
			s1.premult <= cfg.use_src_alpha && cfg.src_premult;
		end
	end

endmodule

// ===== rtl/pab_lane.sv =====
// One color channel, stages 2 to 4: weighted products, divide by 65025
// through a reciprocal multiply, premultiplied add with saturation.
// Depends on pab_pkg.
module pab_lane (
	input  logic                         clk,
	input  pab_pkg::stage_en_t           en,
	input  logic [pab_pkg::CH_W-1:0]     src_s1,
	input  logic [pab_pkg::CH_W-1:0]     dst_s1,
	input  logic [pab_pkg::WEIGHT_W-1:0] weight_s1,
	input  logic                         premult_s1,
	output logic [pab_pkg::CH_W-1:0]     res_s4
);
	import pab_pkg::*;

	localparam int PROD_W = NUM_W + RECIP_W;

	logic [WEIGHT_W-1:0] inv_weight;
	logic [NUM_W-1:0]    src_prod;
	logic [NUM_W-1:0]    dst_prod;
	logic [NUM_W-1:0]    num_s2;
	logic [CH_W-1:0]     src_s2;
	logic                premult_s2;
	logic [PROD_W-1:0]   recip_prod;
	logic [CH_W-1:0]     quot_s3;
	logic [CH_W-1:0]     src_s3;
	logic                premult_s3;
	logic [CH_W:0]       sat_sum;

	assign inv_weight = FULL_WEIGHT - weight_s1;
	assign src_prod   = {{(NUM_W-CH_W){1'b0}}, src_s1} *
	                    {{(NUM_W-WEIGHT_W){1'b0}}, weight_s1};
	assign dst_prod   = {{(NUM_W-CH_W){1'b0}}, dst_s1} *
	                    {{(NUM_W-WEIGHT_W){1'b0}}, inv_weight};

	always_ff @(posedge clk) begin
		if (en.s2) begin
			num_s2     <= premult_s1 ? dst_prod : src_prod + dst_prod;
			src_s2     <= src_s1;
			premult_s2 <= premult_s1;
		end
	end

	assign recip_prod = {{RECIP_W{1'b0}}, num_s2} * {{NUM_W{1'b0}}, RECIP};

	always_ff @(posedge clk) begin
		if (en.s3) begin
			quot_s3    <= recip_prod[RECIP_SHIFT +: CH_W];
			src_s3     <= src_s2;
			premult_s3 <= premult_s2;
		end
	end

	assign sat_sum = {1'b0, src_s3} + {1'b0, quot_s3};

	always_ff @(posedge clk) begin
		if (en.s4) begin
			if (!premult_s3) begin
				res_s4 <= quot_s3;
			end else if (sat_sum[CH_W]) begin
				res_s4 <= ALPHA_MAX;
			end else begin
				res_s4 <= sat_sum[CH_W-1:0];
			end
		end
	end

endmodule

// ===== rtl/pab_checker.sv =====
// Port-level assertions for the pixel alpha blend core, bound to the top.
// Depends on pab_pkg and pixel_alpha_blend_core.
module pab_checker (
	input logic                      clk,
	input logic                      arst_n,
	input logic                      in_valid,
	input logic                      in_ready,
	input logic                      out_valid,
	input logic                      out_ready,
	input logic [pab_pkg::PIX_W-1:0] out_pixel
);
	import pab_pkg::*;

	logic in_acc;
	assign in_acc = in_valid && in_ready;

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("output transaction dropped while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(out_pixel))
		else $error("output pixel changed while stalled");

	a_empty_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input stalled with output stage empty");

	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc ##1 out_ready ##1 out_ready ##1 out_ready |=> out_valid)
		else $error("accepted transaction did not reach the output");

endmodule

bind pixel_alpha_blend_core pab_checker u_pab_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (pix_in.valid),
	.in_ready  (pix_in.ready),
	.out_valid (pix_out.valid),
	.out_ready (pix_out.ready),
	.out_pixel (pix_out.out_pixel)
);

// ===== sim/pixel_alpha_blend_core_test.sv =====
// Self-checking testbench for pixel_alpha_blend_core: random valid/ready pacing on both
// channels, register phases between drained bursts, results checked in order.
// Depends on pab_pkg, pab_if and the core RTL.
module pixel_alpha_blend_core_test;
	timeunit 1ns;
	timeprecision 1ps;

	import pab_pkg::*;

	localparam int unsigned WEIGHT_ONE = 32'(FULL_WEIGHT);
	localparam int          QUIET_LIMIT = 4000;
	localparam int          PIPE_SETTLE = 8;

	typedef struct {
		logic [PIX_W-1:0] dst;
		logic [PIX_W-1:0] src;
		int               gap;
		bit               drain;
	} pixel_pair_t;

	logic clk = 1'b0;
	logic arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_idx;
	logic [CFG_DATA_W-1:0] cfg_data;

	pab_in_if  pix_in_ch();
	pab_out_if pix_out_ch();

	pixel_alpha_blend_core u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_idx  (cfg_idx),
		.cfg_data (cfg_data),
		.pix_in   (pix_in_ch),
		.pix_out  (pix_out_ch)
	);

	always #5 clk = ~clk;

	cfg_t             blend_cfg;
	pixel_pair_t      pending_pairs[$];
	logic [PIX_W-1:0] blended_expect[$];
	int               pairs_issued;
	int               pixels_seen;
	int               mismatch_count;
	int               quiet_cycles;
	bit               sender_steady;

	function automatic logic [PIX_W-1:0] blend_pixel(logic [PIX_W-1:0] dst,
		logic [PIX_W-1:0] src);
		logic [CH_W-1:0]  src_alpha;
		int unsigned      weight;
		int unsigned      inv;
		int unsigned      s;
		int unsigned      d;
		int unsigned      v;
		logic [PIX_W-1:0] res;
		bit               premult;
		if (!blend_cfg.use_src_alpha && blend_cfg.global_alpha == ALPHA_MAX)
			return src;
		src_alpha = blend_cfg.use_src_alpha ? src[31:24] : ALPHA_MAX;
		weight = 32'(src_alpha);
		weight = weight * 32'(blend_cfg.global_alpha);
		if (weight == 0)
			return dst;
		premult = blend_cfg.use_src_alpha && blend_cfg.src_premult;
		inv = WEIGHT_ONE - weight;
		res = '0;
		for (int k = 0; k < NUM_CH; k++) begin
			s = 32'(src[CH_W*k +: CH_W]);
			d = 32'(dst[CH_W*k +: CH_W]);
			if (premult) begin
				v = s + (d * inv) / WEIGHT_ONE;
				if (v > 255)
					v = 255;
			end else begin
				v = (s * weight + d * inv) / WEIGHT_ONE;
			end
			res[CH_W*k +: CH_W] = v[CH_W-1:0];
		end
		return res;
	endfunction

	function automatic logic [PIX_W-1:0] random_pixel();
		logic [PIX_W-1:0] p;
		p = $urandom;
		case ($urandom_range(0, 7))
			0: p[31:24] = 8'h00;
			1: p[31:24] = 8'hFF;
			2: p[23:0] = 24'hFFFFFF;
			3: p[23:0] = 24'h000000;
			default: ;
		endcase
		return p;
	endfunction

	task automatic queue_pair(logic [PIX_W-1:0] dst, logic [PIX_W-1:0] src);
		pixel_pair_t p;
		p.dst = dst;
		p.src = src;
		p.gap = sender_steady ? 0 : $urandom_range(0, 7);
		p.drain = 1'b0;
		pending_pairs.push_back(p);
	endtask

	task automatic queue_random(int count);
		for (int i = 0; i < count; i++) begin
			if (i % 20 == 0)
				sender_steady = ($urandom_range(0, 3) == 0);
			queue_pair(random_pixel(), random_pixel());
		end
	endtask

	task automatic wait_idle();
		do
			@(negedge clk);
		while (pending_pairs.size() != 0 || pixels_seen != pairs_issued);
		repeat (PIPE_SETTLE) @(posedge clk);
	endtask

	task automatic apply_config(logic [CH_W-1:0] ga, logic usa, logic pm);
		logic [CFG_DATA_W-2:0] junk;
		wait_idle();
		@(posedge clk);
		cfg_we   <= 1'b1;
		cfg_idx  <= CFG_GLOBAL_ALPHA;
		cfg_data <= ga;
		@(posedge clk);
		junk = (CFG_DATA_W-1)'($urandom);
		cfg_idx  <= CFG_USE_SRC_ALPHA;
		cfg_data <= {junk, usa};
		@(posedge clk);
		junk = (CFG_DATA_W-1)'($urandom);
		cfg_idx  <= CFG_SRC_PREMULT;
		cfg_data <= {junk, pm};
		@(posedge clk);
		cfg_we <= 1'b0;
		blend_cfg.global_alpha  = ga;
		blend_cfg.use_src_alpha = usa;
		blend_cfg.src_premult   = pm;
		@(negedge clk);
	endtask

	// sender
	logic        in_fire;
	int          gap_left;
	bit          gap_loaded;
	pixel_pair_t head;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pix_in_ch.valid     <= 1'b0;
			pix_in_ch.dst_pixel <= '0;
			pix_in_ch.src_pixel <= '0;
			pairs_issued        <= 0;
			gap_loaded = 1'b0;
			gap_left   = 0;
		end else begin
			in_fire = pix_in_ch.valid && pix_in_ch.ready;
			if (in_fire)
				blended_expect.push_back(blend_pixel(pix_in_ch.dst_pixel,
					pix_in_ch.src_pixel));
			if (!pix_in_ch.valid || in_fire) begin
				if (pending_pairs.size() == 0) begin
					pix_in_ch.valid <= 1'b0;
				end else begin
					if (!gap_loaded) begin
						gap_left   = pending_pairs[0].gap;
						gap_loaded = 1'b1;
					end
					if (gap_left != 0) begin
						gap_left = gap_left - 1;
						pix_in_ch.valid <= 1'b0;
					end else if (pending_pairs[0].drain && pixels_seen != pairs_issued) begin
						pix_in_ch.valid <= 1'b0;
					end else begin
						head = pending_pairs.pop_front();
						gap_loaded = 1'b0;
						pix_in_ch.valid     <= 1'b1;
						pix_in_ch.dst_pixel <= head.dst;
						pix_in_ch.src_pixel <= head.src;
						pairs_issued        <= pairs_issued + 1;
					end
				end
			end
		end
	end

	// receiver
	int               stall_left;
	int               stretch_left;
	bit               receiver_steady;
	logic [PIX_W-1:0] want;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pix_out_ch.ready <= 1'b0;
			pixels_seen      <= 0;
			stall_left      = 0;
			stretch_left    = 0;
			receiver_steady = 1'b0;
		end else begin
			if (pix_out_ch.valid && pix_out_ch.ready) begin
				pixels_seen <= pixels_seen + 1;
				if (blended_expect.size() == 0) begin
					$error("out_pixel transaction with nothing pending: actual %h",
						pix_out_ch.out_pixel);
					mismatch_count++;
				end else begin
					want = blended_expect.pop_front();
					if (pix_out_ch.out_pixel !== want) begin
						$error("out_pixel mismatch: expected %h, actual %h", want,
							pix_out_ch.out_pixel);
						mismatch_count++;
					end
				end
				stall_left = receiver_steady ? 0 : $urandom_range(0, 7);
			end
			if (stretch_left == 0) begin
				stretch_left    = $urandom_range(20, 80);
				receiver_steady = ($urandom_range(0, 3) == 0);
			end else begin
				stretch_left--;
			end
			if (stall_left != 0) begin
				stall_left--;
				pix_out_ch.ready <= 1'b0;
			end else begin
				pix_out_ch.ready <= 1'b1;
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		if (!arst_n || cfg_we || (pix_in_ch.valid && pix_in_ch.ready)
			|| (pix_out_ch.valid && pix_out_ch.ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= QUIET_LIMIT) begin
			$display("pixel_alpha_blend_core regression: fail");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		arst_n              = 1'b0;
		cfg_we              = 1'b0;
		cfg_idx             = '0;
		cfg_data            = '0;
		pix_in_ch.valid     = 1'b0;
		pix_in_ch.dst_pixel = '0;
		pix_in_ch.src_pixel = '0;
		pix_out_ch.ready    = 1'b0;
		quiet_cycles        = 0;
		mismatch_count      = 0;
		sender_steady       = 1'b0;
		blend_cfg.global_alpha  = ALPHA_MAX;
		blend_cfg.use_src_alpha = 1'b1;
		blend_cfg.src_premult   = 1'b0;

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// reset settings: zero weight, full weight, partial weights, extremes
		queue_pair(32'h12345678, 32'h00ABCDEF);
		queue_pair(32'h00000000, 32'hFFFFFFFF);
		queue_pair(32'hFFFFFFFF, 32'hFF000000);
		queue_pair(32'h00000000, 32'h80FFFFFF);
		queue_pair(32'hFF000000, 32'h01FFFFFF);
		queue_pair(32'hABCDEF01, 32'hFE123456);
		queue_pair(32'h00000000, 32'h00000000);
		queue_pair(32'hFFFFFFFF, 32'hFFFFFFFF);
		queue_random(25);
		pending_pairs[$].drain = 1'b1;
		queue_random(25);

		// opaque copy
		apply_config(8'hFF, 1'b0, 1'b0);
		queue_pair(32'hFFFFFFFF, 32'h00123456);
		queue_pair(32'h00000000, 32'hA5C3E1F0);
		queue_random(30);

		// zero weight from global alpha
		apply_config(8'h00, 1'b1, 1'b0);
		queue_pair(32'h87654321, 32'hFFFFFFFF);
		queue_random(20);

		// premultiplied, including saturation
		apply_config(8'hFF, 1'b1, 1'b1);
		queue_pair(32'h00FFFFFF, 32'h80FFFFFF);
		queue_pair(32'hFFFFFFFF, 32'h00FFFFFF);
		queue_pair(32'hFFFFFFFF, 32'hFF808080);
		queue_pair(32'h80808080, 32'h40102030);
		queue_random(50);

		// premultiplied flag ignored without source alpha
		apply_config(8'd100, 1'b0, 1'b1);
		queue_pair(32'hFFFFFFFF, 32'h00000000);
		queue_pair(32'h00000000, 32'hFFFFFFFF);
		queue_random(30);

		apply_config(8'h00, 1'b0, 1'b0);
		queue_random(15);

		apply_config(8'h01, 1'b1, 1'b0);
		queue_random(30);

		for (int ph = 0; ph < 6; ph++) begin
			case ($urandom_range(0, 3))
				0: apply_config(8'h00, 1'($urandom_range(0, 1)),
					1'($urandom_range(0, 1)));
				1: apply_config(8'hFF, 1'($urandom_range(0, 1)),
					1'($urandom_range(0, 1)));
				default: apply_config(8'($urandom_range(0, 255)),
					1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
			endcase
			queue_random(30);
		end

		wait_idle();
		if (blended_expect.size() != 0) begin
			$error("out_pixel: %0d transactions never returned", blended_expect.size());
			mismatch_count++;
		end
		if (mismatch_count == 0)
			$display("pixel_alpha_blend_core regression: pass");
		else
			$display("pixel_alpha_blend_core regression: fail");
		$finish;
	end

endmodule

// ===== sim.f =====
rtl/pab_pkg.sv
rtl/pab_if.sv
rtl/pab_weight.sv
rtl/pab_lane.sv
rtl/pixel_alpha_blend_core.sv
rtl/pab_checker.sv
sim/pixel_alpha_blend_core_test.sv
